>>> rtl/core/ltbo_pkg.sv
package ltbo_pkg;

  localparam int FRAME_ADDR_MASK_DEFAULT = 131071;
  localparam int LINE_WIDTH_DEFAULT      = 320;
  localparam int LINE_COUNT_DEFAULT      = 224;
  localparam int PALETTE_ENTRIES         = 256;
  localparam int PALETTE_ADDR_BITS       = $clog2(PALETTE_ENTRIES);
  localparam int FRAME_BITS_MAX          = 18;

  localparam logic [1:0] CMD_FRAME_WRITE   = 2'd0;
  localparam logic [1:0] CMD_PALETTE_WRITE = 2'd1;
  localparam logic [1:0] CMD_COMPOSITE     = 2'd2;

  localparam logic [1:0] MODE_PALETTE = 2'd1;
  localparam logic [1:0] MODE_DIRECT  = 2'd2;

  localparam logic REG_DISPLAY_MODE   = 1'b0;
  localparam logic REG_OVERLAY_ENABLE = 1'b1;

  localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;
  localparam logic [28:0] EXPAND_RECIP  = 29'd8625630;

  typedef struct packed {
    logic [1:0]  command;
    logic [16:0] address;
    logic [15:0] data;
    logic [8:0]  column;
    logic [7:0]  line;
    logic [31:0] under_pixel;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        overlay_shown;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TABLE_HI,
    ST_TABLE_LO,
    ST_TABLE_CHECK,
    ST_INDEX,
    ST_PALETTE,
    ST_COLOR_HI,
    ST_COLOR_LO
  } state_t;

  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [28:0] p;
    p = 29'(c) * EXPAND_RECIP;
    return p[27:20];
  endfunction

  function automatic logic [31:0] rgb555_to_argb(input logic [15:0] col);
    return {ALPHA_OPAQUE, expand5(col[4:0]), expand5(col[9:5]), expand5(col[14:10])};
  endfunction

endpackage

>>> rtl/core/ltbo_ram.sv
module ltbo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/line_table_bitmap_overlay.sv
// Write commands never leave idle; the next transaction may start in the following cycle.
// A composite result strobes after ST_TABLE_HI if bypassed, ST_TABLE_CHECK on a zero
// line word, ST_INDEX for a transparent palette pixel, else ST_PALETTE or ST_COLOR_LO:
// each lookup step is one synchronous read of the byte frame store or the palette RAM.
// A new transaction is taken in the cycle its result strobes; results cannot be stalled.
// After reset, busy stays high while clear_addr steps from 0 to FRAME_ADDR_MASK and
// both stores are swept to zero; configuration writes are taken throughout.
module line_table_bitmap_overlay #(
  parameter int FRAME_ADDR_MASK = ltbo_pkg::FRAME_ADDR_MASK_DEFAULT,
  parameter int LINE_WIDTH      = ltbo_pkg::LINE_WIDTH_DEFAULT,
  parameter int LINE_COUNT      = ltbo_pkg::LINE_COUNT_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  ltbo_pkg::in_t   request,
  output logic            busy,
  output ltbo_pkg::out_t  result,
  output logic            result_valid,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  import ltbo_pkg::*;

  localparam int FaW = $clog2(FRAME_ADDR_MASK + 1);
  localparam logic [FRAME_BITS_MAX-1:0] FaMask = FRAME_BITS_MAX'(FRAME_ADDR_MASK);

  function automatic logic [FaW-1:0] frame_index(input logic [FRAME_BITS_MAX-1:0] a);
    logic [FRAME_BITS_MAX-1:0] m;
    m = a & FaMask;
    return m[FaW-1:0];
  endfunction

  state_t state, state_next;
  in_t    req;
  out_t   result_next;
  logic   result_valid_next;

  logic [FaW-1:0] clear_addr;
  logic [7:0]     byte_hi;
  logic           capture_hi;
  logic [16:0]    color_addr, color_addr_next;

  logic [1:0] display_mode;
  logic       overlay_enable;

  logic           frame_we;
  logic [FaW-1:0] frame_waddr, frame_raddr;
  logic [7:0]     frame_wdata, frame_rdata;

  logic                         pal_we;
  logic [PALETTE_ADDR_BITS-1:0] pal_waddr, pal_raddr;
  logic [15:0]                  pal_wdata, pal_rdata;

  logic                      accept;
  logic                      bypass;
  logic [15:0]               entry;
  logic [16:0]               base, index_addr, direct_addr;
  logic [FRAME_BITS_MAX-1:0] table_addr;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign pready = 1'b1;

  assign bypass = ({2'b00, req.column} >= 11'(LINE_WIDTH)) ||
                  ({2'b00, req.line} >= 10'(LINE_COUNT)) ||
                  !overlay_enable ||
                  ((display_mode != MODE_PALETTE) && (display_mode != MODE_DIRECT));

  assign table_addr  = FRAME_BITS_MAX'({req.line, 1'b0});
  assign entry       = {byte_hi, frame_rdata};
  assign base        = {entry, 1'b0};
  assign index_addr  = base + 17'(req.column);
  assign direct_addr = base + 17'({req.column, 1'b0});

  ltbo_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_ADDR_MASK + 1)
  ) u_frame_ram (
    .clk  (clk),
    .we   (frame_we),
    .waddr(frame_waddr),
    .wdata(frame_wdata),
    .raddr(frame_raddr),
    .rdata(frame_rdata)
  );

  ltbo_ram #(
    .WIDTH(16),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette_ram (
    .clk  (clk),
    .we   (pal_we),
    .waddr(pal_waddr),
    .wdata(pal_wdata),
    .raddr(pal_raddr),
    .rdata(pal_rdata)
  );

  always_comb begin
    if (state == ST_CLEAR) begin
      frame_we    = 1'b1;
      frame_waddr = clear_addr;
      frame_wdata = '0;
      pal_we      = (clear_addr[FaW-1:PALETTE_ADDR_BITS] == '0);
      pal_waddr   = clear_addr[PALETTE_ADDR_BITS-1:0];
      pal_wdata   = '0;
    end else begin
      frame_we    = accept && (request.command == CMD_FRAME_WRITE);
      frame_waddr = frame_index(FRAME_BITS_MAX'(request.address));
      frame_wdata = request.data[7:0];
      pal_we      = accept && (request.command == CMD_PALETTE_WRITE);
      pal_waddr   = request.address[PALETTE_ADDR_BITS-1:0];
      pal_wdata   = request.data;
    end
  end

  always_comb begin
    state_next                = state;
    frame_raddr               = '0;
    pal_raddr                 = frame_rdata[PALETTE_ADDR_BITS-1:0];
    capture_hi                = 1'b0;
    color_addr_next           = color_addr;
    result_valid_next         = 1'b0;
    result_next.pixel_out     = req.under_pixel;
    result_next.overlay_shown = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clear_addr == FaMask[FaW-1:0]) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (request.command == CMD_COMPOSITE)) begin
          state_next = ST_TABLE_HI;
        end
      end
      ST_TABLE_HI: begin
        if (bypass) begin
          result_valid_next = 1'b1;
          state_next        = ST_IDLE;
        end else begin
          frame_raddr = frame_index(table_addr);
          state_next  = ST_TABLE_LO;
        end
      end
      ST_TABLE_LO: begin
        frame_raddr = frame_index(table_addr + FRAME_BITS_MAX'(1));
        capture_hi  = 1'b1;
        state_next  = ST_TABLE_CHECK;
      end
      ST_TABLE_CHECK: begin
        if (entry == '0) begin
          result_valid_next = 1'b1;
          state_next        = ST_IDLE;
        end else if (display_mode == MODE_PALETTE) begin
          frame_raddr = frame_index(FRAME_BITS_MAX'(index_addr));
          state_next  = ST_INDEX;
        end else begin
          frame_raddr     = frame_index(FRAME_BITS_MAX'(direct_addr));
          color_addr_next = direct_addr;
          state_next      = ST_COLOR_HI;
        end
      end
      ST_INDEX: begin
        if (frame_rdata == '0) begin
          result_valid_next = 1'b1;
          state_next        = ST_IDLE;
        end else begin
          state_next = ST_PALETTE;
        end
      end
      ST_PALETTE: begin
        result_valid_next         = 1'b1;
        result_next.pixel_out     = rgb555_to_argb(pal_rdata);
        result_next.overlay_shown = 1'b1;
        state_next                = ST_IDLE;
      end
      ST_COLOR_HI: begin
        frame_raddr = frame_index(FRAME_BITS_MAX'(color_addr) + FRAME_BITS_MAX'(1));
        capture_hi  = 1'b1;
        state_next  = ST_COLOR_LO;
      end
      ST_COLOR_LO: begin
        result_valid_next = 1'b1;
        state_next        = ST_IDLE;
        if (entry != '0) begin
          result_next.pixel_out     = rgb555_to_argb(entry);
          result_next.overlay_shown = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clear_addr     <= '0;
      result_valid   <= 1'b0;
      display_mode   <= 2'd0;
      overlay_enable <= 1'b1;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + FaW'(1);
      end
      if (psel && penable && pwrite) begin
        unique case (paddr[2])
          REG_DISPLAY_MODE:   display_mode   <= pwdata[1:0];
          REG_OVERLAY_ENABLE: overlay_enable <= pwdata[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= request;
    end
    if (capture_hi) begin
      byte_hi <= frame_rdata;
    end
    color_addr <= color_addr_next;
    result     <= result_next;
  end

  always_comb begin
    unique case (paddr[2])
      REG_DISPLAY_MODE:   prdata = {30'd0, display_mode};
      REG_OVERLAY_ENABLE: prdata = {31'd0, overlay_enable};
    endcase
  end

endmodule

>>> rtl/core/ltbo_checker.sv
module ltbo_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input ltbo_pkg::in_t request,
  input logic          result_valid,
  input logic          pready
);

  import ltbo_pkg::*;

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  a_write_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.command != CMD_COMPOSITE)) |=> !busy)
    else $error("store write transaction made the block busy");

  a_composite_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.command == CMD_COMPOSITE)) |=> (busy && !result_valid))
    else $error("composite transaction did not hold busy");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind line_table_bitmap_overlay ltbo_checker u_checker (.*);

>>> verif/line_table_bitmap_overlay_test.sv
module line_table_bitmap_overlay_test;
  import ltbo_pkg::*;

  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam logic [1:0] MODE_BLANK     = 2'd0;
  localparam logic [1:0] MODE_BLANK_ALT = 2'd3;
  localparam int         FRAME_BYTES    = FRAME_ADDR_MASK_DEFAULT + 1;
  localparam int         ACTIVE_LINES   = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  in_t         request = '0;
  logic        busy;
  out_t        result;
  logic        result_valid;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  line_table_bitmap_overlay dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .result(result),
    .result_valid(result_valid),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [7:0]  fstore [0:FRAME_BYTES-1];
  logic [15:0] pstore [0:PALETTE_ENTRIES-1];
  logic [1:0]  mode_q = 2'd0;
  logic        enable_q = 1'b1;

  in_t  pending [$];
  out_t pixel_expect [$];
  int   queued = 0;
  int   accepted = 0;
  int   errors = 0;
  int   gap_max = 12;
  int   wait_cnt = 0;
  int   n_composite = 0;
  int   n_shown = 0;
  int   n_writes = 0;
  int   n_ignored = 0;
  int   n_settings = 0;

  logic [7:0]  act_line [ACTIVE_LINES];
  logic [16:0] act_base [ACTIVE_LINES];

  initial begin
    for (int i = 0; i < FRAME_BYTES; i++) fstore[i] = 8'h00;
    for (int i = 0; i < PALETTE_ENTRIES; i++) pstore[i] = 16'h0000;
  end

  function automatic logic [7:0] widen5(logic [4:0] c);
    return 8'((int'(c) * 255) / 31);
  endfunction

  function automatic logic [15:0] frame_word(logic [16:0] a);
    logic [16:0] a1;
    a1 = a + 17'd1;
    return {fstore[a], fstore[a1]};
  endfunction

  task automatic overlay_predict(in_t t);
    out_t        res;
    logic [15:0] entry;
    logic [15:0] colr;
    logic [16:0] base;
    logic [16:0] a;
    logic [7:0]  idx;
    logic        hit;
    case (t.command)
      CMD_FRAME_WRITE: begin
        fstore[t.address] = t.data[7:0];
        n_writes++;
      end
      CMD_PALETTE_WRITE: begin
        pstore[t.address[7:0]] = t.data;
        n_writes++;
      end
      CMD_COMPOSITE: begin
        res.pixel_out = t.under_pixel;
        res.overlay_shown = 1'b0;
        hit = 1'b0;
        colr = '0;
        if (t.column < LINE_WIDTH_DEFAULT && t.line < LINE_COUNT_DEFAULT && enable_q &&
            (mode_q == MODE_PALETTE || mode_q == MODE_DIRECT)) begin
          entry = frame_word({8'd0, t.line, 1'b0});
          base = {entry, 1'b0};
          if (entry != 16'd0) begin
            if (mode_q == MODE_PALETTE) begin
              a = base + 17'(t.column);
              idx = fstore[a];
              colr = pstore[idx];
              hit = (idx != 8'd0);
            end else begin
              a = base + {7'd0, t.column, 1'b0};
              colr = frame_word(a);
              hit = (colr != 16'd0);
            end
          end
        end
        if (hit) begin
          res.pixel_out = {ALPHA_OPAQUE, widen5(colr[4:0]), widen5(colr[9:5]),
                           widen5(colr[14:10])};
          res.overlay_shown = 1'b1;
          n_shown++;
        end
        pixel_expect.push_back(res);
        n_composite++;
      end
      default: n_ignored++;
    endcase
  endtask

  always @(posedge clk) begin : drive
    logic nxt_start;
    int   nxt_wait;
    nxt_start = start;
    nxt_wait = wait_cnt;
    if (rst) begin
      nxt_start = 1'b0;
      nxt_wait = 0;
    end else begin
      if (start && !busy) begin
        overlay_predict(request);
        accepted++;
        nxt_start = 1'b0;
        nxt_wait = $urandom_range(0, gap_max);
      end
      if (!nxt_start) begin
        if (nxt_wait > 0) begin
          nxt_wait--;
        end else if (pending.size() > 0) begin
          request <= pending.pop_front();
          nxt_start = 1'b1;
        end
      end
    end
    start <= nxt_start;
    wait_cnt <= nxt_wait;
  end

  always @(posedge clk) begin : check
    out_t want;
    if (!rst && result_valid) begin
      if (pixel_expect.size() == 0) begin
        $error("result with no transaction pending: %h", result);
        errors++;
      end else begin
        want = pixel_expect.pop_front();
        if (result.pixel_out !== want.pixel_out) begin
          $error("pixel_out: expected %h, actual %h", want.pixel_out, result.pixel_out);
          errors++;
        end
        if (result.overlay_shown !== want.overlay_shown) begin
          $error("overlay_shown: expected %b, actual %b", want.overlay_shown,
                 result.overlay_shown);
          errors++;
        end
      end
    end
  end

  function automatic in_t pack_req(logic [1:0] cmd, logic [16:0] addr, logic [15:0] dat,
                                   logic [8:0] col, logic [7:0] ln, logic [31:0] under);
    in_t t;
    t.command = cmd;
    t.address = addr;
    t.data = dat;
    t.column = col;
    t.line = ln;
    t.under_pixel = under;
    return t;
  endfunction

  task automatic push(in_t t);
    pending.push_back(t);
    queued++;
  endtask

  task automatic put_frame(logic [16:0] addr, logic [7:0] b);
    push(pack_req(CMD_FRAME_WRITE, addr, {8'($urandom), b}, 9'($urandom), 8'($urandom),
                  $urandom));
  endtask

  task automatic put_palette(logic [16:0] addr, logic [15:0] w);
    push(pack_req(CMD_PALETTE_WRITE, addr, w, 9'($urandom), 8'($urandom), $urandom));
  endtask

  task automatic put_pixel(logic [8:0] col, logic [7:0] ln, logic [31:0] under);
    push(pack_req(CMD_COMPOSITE, 17'($urandom), 16'($urandom), col, ln, under));
  endtask

  task automatic settle();
    while (accepted != queued || pixel_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_DISPLAY_MODE) mode_q = val[1:0];
    else enable_q = val[0];
    n_settings++;
  endtask

  task automatic set_table(int k, logic [15:0] w);
    put_frame({8'd0, act_line[k], 1'b0}, w[15:8]);
    put_frame({8'd0, act_line[k], 1'b1}, w[7:0]);
    act_base[k] = {w, 1'b0};
  endtask

  task automatic random_phase(int n);
    int          k;
    int          r;
    int          c;
    logic [16:0] a;
    logic [15:0] w;
    logic [7:0]  b;
    for (k = 0; k < ACTIVE_LINES; k++) begin
      act_line[k] = 8'($urandom_range(0, LINE_COUNT_DEFAULT - 1));
      if ($urandom_range(0, 3) == 0) w = 16'hFFF0 | 16'($urandom_range(0, 15));
      else w = 16'($urandom_range(1, 16'hFFFF));
      set_table(k, w);
    end
    repeat (n) begin
      k = $urandom_range(0, ACTIVE_LINES - 1);
      r = $urandom_range(0, 99);
      c = ($urandom_range(0, 4) == 0) ? $urandom_range(0, LINE_WIDTH_DEFAULT - 1)
                                      : $urandom_range(0, 15);
      if (r < 45) begin
        put_pixel(9'(c), act_line[k], $urandom);
      end else if (r < 70) begin
        if ($urandom_range(0, 1) == 1) a = act_base[k] + 17'(c);
        else a = act_base[k] + 17'(2 * c) + 17'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0: b = 8'h00;
          1: b = 8'($urandom);
          default: b = 8'($urandom_range(1, 15));
        endcase
        put_frame(a, b);
      end else if (r < 80) begin
        a = {9'($urandom), ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 15))
                                                       : 8'($urandom)};
        put_palette(a, ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom));
      end else if (r < 85) begin
        set_table(k, ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom));
      end else if (r < 95) begin
        put_pixel(9'($urandom), 8'($urandom), $urandom);
      end else if (r < 98) begin
        put_frame(17'($urandom), 8'($urandom));
      end else begin
        push(pack_req(CMD_UNUSED, 17'($urandom), 16'($urandom), 9'($urandom), 8'($urandom),
                      $urandom));
      end
    end
  endtask

  initial begin : main
    logic [1:0] modes [7];
    logic       enables [7];
    int         gaps [7];
    modes = '{MODE_PALETTE, MODE_DIRECT, MODE_PALETTE, MODE_DIRECT, MODE_BLANK,
              MODE_BLANK_ALT, MODE_PALETTE};
    enables = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
    gaps = '{12, 0, 12, 5, 12, 0, 12};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    put_frame(17'h00000, 8'h00);
    put_frame(17'h00001, 8'h80);
    put_frame(17'h00105, 8'h07);
    put_frame(17'h00106, 8'hFF);
    put_palette({9'h1FF, 8'h07}, 16'hFFFF);
    put_palette({9'h000, 8'hFF}, 16'h8000);
    put_pixel(9'd5, 8'd0, 32'h0000_0000);
    push(pack_req(CMD_UNUSED, '1, '1, '1, '1, '1));
    settle();
    reg_write(REG_DISPLAY_MODE, {30'($urandom), MODE_PALETTE} & 32'hFFFF_FFFD);
    put_pixel(9'd5, 8'd0, 32'hFFFF_FFFF);
    put_pixel(9'd6, 8'd0, 32'h1234_5678);
    put_pixel(9'd7, 8'd0, 32'hFFFF_FFFF);
    put_pixel(9'd320, 8'd0, 32'hA5A5_A5A5);
    put_pixel(9'd511, 8'd255, 32'h5A5A_5A5A);
    put_pixel(9'd0, 8'd224, 32'hFFFF_FFFF);
    put_pixel(9'd5, 8'd1, 32'h0F0F_0F0F);
    put_frame(17'd446, 8'hFF);
    put_frame(17'd447, 8'hFF);
    put_frame(17'h1FFFF, 8'h07);
    put_pixel(9'd1, 8'd223, 32'h0000_0000);
    settle();
    reg_write(REG_DISPLAY_MODE, {30'd0, MODE_DIRECT});
    put_pixel(9'd0, 8'd223, 32'h0000_0000);
    put_pixel(9'd1, 8'd223, 32'h0000_0000);
    put_pixel(9'd2, 8'd0, 32'h0000_0000);
    settle();
    reg_write(REG_OVERLAY_ENABLE, 32'hFFFF_FFFE);
    put_pixel(9'd2, 8'd0, 32'hCAFE_0001);
    settle();
    reg_write(REG_DISPLAY_MODE, {30'h3FFF_FFFF, MODE_BLANK_ALT});
    reg_write(REG_OVERLAY_ENABLE, 32'h0000_0001);
    put_pixel(9'd2, 8'd0, 32'hCAFE_0002);
    settle();

    for (int p = 0; p < 7; p++) begin
      reg_write(REG_DISPLAY_MODE, {30'($urandom), modes[p]});
      reg_write(REG_OVERLAY_ENABLE, {31'($urandom), enables[p]});
      gap_max = gaps[p];
      random_phase(92);
      settle();
    end

    $display("Covered %0d transactions: %0d composites (%0d overlay pixels), %0d store writes,",
             accepted, n_composite, n_shown, n_writes);
    $display("%0d unused commands, %0d register writes across all modes and enable states",
             n_ignored, n_settings);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
